// ===== sv/kcrq_pkg.sv =====
`default_nettype none
package kcrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ENTRY_BYTES = 64;

   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int POS_W  = $clog2(ENTRY_BYTES);
   localparam int FILL_W = $clog2(ENTRY_BYTES + 1);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = SLOT_W + POS_W;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD_LEN   = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_TOO_SMALL = 3'd4;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_POP = 1'b1;

   typedef struct packed {
      logic capture;
      logic search;
      logic hdr_hi;
      logic hdr_lo;
      logic data;
      logic pad;
      logic result;
      logic pop;
      logic stream;
   } kcrq_cmd_type;

   typedef struct packed {
      logic msg_open;
      logic srch_done;
      logic srch_ok;
      logic last;
      logic accepting;
      logic pad_done;
      logic pop_stream;
      logic stream_last;
   } kcrq_sts_type;

endpackage
`default_nettype wire

// ===== sv/kcrq_ctrl.sv =====
`default_nettype none
module kcrq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_op,
   input  wire logic                  req_first_byte,
   input  wire kcrq_pkg::kcrq_sts_type sts,
   output kcrq_pkg::kcrq_cmd_type     cmd,
   output logic                       busy
);
   import kcrq_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_HDR_HI = 4'd2;
   localparam logic [3:0] S_HDR_LO = 4'd3;
   localparam logic [3:0] S_DATA   = 4'd4;
   localparam logic [3:0] S_PAD    = 4'd5;
   localparam logic [3:0] S_RESULT = 4'd6;
   localparam logic [3:0] S_POP    = 4'd7;
   localparam logic [3:0] S_STREAM = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
            if (start) begin
               if (req_op == OP_POP) begin
                  state_in = S_POP;
               end else if (req_first_byte) begin
                  state_in = S_SEARCH;
               end else if (sts.msg_open) begin
                  state_in = S_DATA;
               end
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.srch_done) begin
               state_in = sts.srch_ok ? S_HDR_HI : S_DATA;
            end
         end
         S_HDR_HI: begin
            cmd.hdr_hi = 1'b1;
            state_in   = S_HDR_LO;
         end
         S_HDR_LO: begin
            cmd.hdr_lo = 1'b1;
            state_in   = S_DATA;
         end
         S_DATA: begin
            cmd.data = 1'b1;
            if (sts.last) begin
               state_in = sts.accepting ? S_PAD : S_RESULT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.pad = 1'b1;
            if (sts.pad_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            cmd.result = 1'b1;
            state_in   = S_IDLE;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = sts.pop_stream ? S_STREAM : S_IDLE;
         end
         S_STREAM: begin
            cmd.stream = 1'b1;
            if (sts.stream_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ===== sv/kcrq_dpath.sv =====
`default_nettype none
module kcrq_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kcrq_pkg::kcrq_cmd_type cmd,
   output kcrq_pkg::kcrq_sts_type      sts,
   input  wire logic                   req_op,
   input  wire logic [31:0]            req_dest_key,
   input  wire logic [15:0]            req_msg_length,
   input  wire logic [7:0]             req_msg_byte,
   input  wire logic                   req_first_byte,
   input  wire logic                   req_last_byte,
   input  wire logic [15:0]            req_read_limit,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [7:0]                  rsp_out_byte,
   output logic [31:0]                 rsp_out_key,
   output logic [6:0]                  rsp_entry_size,
   output logic                        rsp_out_last
);
   import kcrq_pkg::*;

   logic [7:0]        mem [ENTRY_BYTES * QUEUE_DEPTH];
   logic [31:0]       keys_ff [QUEUE_DEPTH];
   logic [FILL_W-1:0] fill_ff [QUEUE_DEPTH];

   logic [SLOT_W-1:0] head_ff, tail_ff, active_ff, srch_idx_ff;
   logic [CNT_W-1:0]  count_ff, srch_n_ff;
   logic              msg_open_ff, accepting_ff, opens_new_ff;
   logic [2:0]        held_status_ff;
   logic [FILL_W-1:0] held_len_ff, start_off_ff, seen_ff;
   logic [31:0]       held_key_ff;
   logic [15:0]       it_len_ff, it_limit_ff;
   logic [7:0]        it_byte_ff, rdata_ff;
   logic              it_last_ff;
   logic [POS_W-1:0]  rd_pos_ff;

   logic              rsp_valid_ff, rsp_last_ff;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_key_ff;
   logic [6:0]        rsp_size_ff;

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
      ring_next = (i == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // One shared read port on the key and fill arrays: the search walks it,
   // a pop looks at the head slot.
   logic [SLOT_W-1:0] rd_slot;
   logic [31:0]       key_rd;
   logic [FILL_W-1:0] fill_rd;
   assign rd_slot = (cmd.pop || cmd.stream) ? head_ff : srch_idx_ff;
   assign key_rd  = keys_ff[rd_slot];
   assign fill_rd = fill_ff[rd_slot];

   // Search step.
   logic        bad_len, in_ring, key_hit, too_big, srch_done, srch_ok;
   logic [16:0] app_sum;
   logic [2:0]  srch_status;
   assign bad_len = (it_len_ff == 16'd0) || (it_len_ff >= 16'(ENTRY_BYTES));
   assign in_ring = (srch_n_ff < count_ff);
   assign key_hit = (key_rd == held_key_ff);
   assign app_sum = 17'(fill_rd) + 17'(it_len_ff) + 17'd4;
   assign too_big = (app_sum > 17'(ENTRY_BYTES));
   assign srch_done = bad_len || !in_ring || key_hit;

   always_comb begin
      srch_ok     = 1'b0;
      srch_status = ST_OK;
      if (bad_len) begin
         srch_status = ST_BAD_LEN;
      end else if (in_ring) begin
         srch_status = too_big ? ST_FULL : ST_OK;
         srch_ok     = !too_big;
      end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
         srch_status = ST_FULL;
      end else if (it_len_ff > 16'(ENTRY_BYTES - 2)) begin
         srch_status = ST_BAD_LEN;
      end else begin
         srch_ok = 1'b1;
      end
   end

   // Pop checks.
   logic pop_empty, pop_small, pop_stream, stream_last, pad_done;
   assign pop_empty   = (count_ff == '0);
   assign pop_small   = (it_limit_ff < 16'(fill_rd));
   assign pop_stream  = !pop_empty && !pop_small && (fill_rd != '0);
   assign stream_last = ((FILL_W'(rd_pos_ff) + 1'b1) == fill_rd);
   assign pad_done    = (seen_ff >= held_len_ff);

   assign sts.msg_open    = msg_open_ff;
   assign sts.srch_done   = srch_done;
   assign sts.srch_ok     = srch_ok;
   assign sts.last        = it_last_ff;
   assign sts.accepting   = accepting_ff;
   assign sts.pad_done    = pad_done;
   assign sts.pop_stream  = pop_stream;
   assign sts.stream_last = stream_last;

   // Store write port.
   logic              wr_en, data_wr;
   logic [FILL_W-1:0] wr_pos;
   logic [7:0]        wr_data;
   logic [FILL_W-1:0] data_pos;
   assign data_pos = start_off_ff + FILL_W'(2) + seen_ff;
   assign data_wr  = (cmd.data && accepting_ff && (seen_ff < held_len_ff))
                     || (cmd.pad && !pad_done);

   always_comb begin
      wr_en   = 1'b0;
      wr_pos  = data_pos;
      wr_data = 8'd0;
      if (cmd.hdr_hi) begin
         wr_en   = 1'b1;
         wr_pos  = start_off_ff;
         wr_data = it_len_ff[15:8];
      end else if (cmd.hdr_lo) begin
         wr_en   = 1'b1;
         wr_pos  = start_off_ff + 1'b1;
         wr_data = it_len_ff[7:0];
      end else if (data_wr) begin
         wr_en   = 1'b1;
         wr_data = cmd.data ? it_byte_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{active_ff, wr_pos[POS_W-1:0]}] <= wr_data;
      end
      if (cmd.stream) begin
         rdata_ff <= mem[{head_ff, rd_pos_ff}];
      end else begin
         rdata_ff <= 8'd0;
      end
   end

   // Key array: holds the entry keys, written when a new entry commits.
   always_ff @(posedge clock) begin
      if (cmd.pad && pad_done && opens_new_ff) begin
         keys_ff[active_ff] <= held_key_ff;
      end
   end

   // Item capture, search walk, byte counts and response registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         it_len_ff   <= req_msg_length;
         it_byte_ff  <= req_msg_byte;
         it_last_ff  <= req_last_byte;
         it_limit_ff <= req_read_limit;
         if (req_op == OP_ADD && req_first_byte) begin
            held_key_ff <= req_dest_key;
            held_len_ff <= req_msg_length[FILL_W-1:0];
            srch_idx_ff <= head_ff;
            srch_n_ff   <= '0;
         end
      end
      if (cmd.search && !srch_done) begin
         srch_idx_ff <= ring_next(srch_idx_ff);
         srch_n_ff   <= srch_n_ff + 1'b1;
      end
      if (cmd.search && srch_done) begin
         held_status_ff <= srch_status;
         if (in_ring) begin
            active_ff    <= srch_idx_ff;
            start_off_ff <= fill_rd;
            opens_new_ff <= 1'b0;
         end else begin
            active_ff    <= tail_ff;
            start_off_ff <= '0;
            opens_new_ff <= 1'b1;
         end
      end
      if (cmd.pop) begin
         rd_pos_ff <= '0;
      end else if (cmd.stream) begin
         rd_pos_ff <= rd_pos_ff + 1'b1;
      end
      if (cmd.capture && req_op == OP_ADD && req_first_byte) begin
         seen_ff <= '0;
      end else if (data_wr) begin
         seen_ff <= seen_ff + 1'b1;
      end
      if (cmd.result) begin
         rsp_status_ff <= held_status_ff;
         rsp_key_ff    <= '0;
         rsp_size_ff   <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.pop) begin
         rsp_status_ff <= pop_empty ? ST_EMPTY : (pop_small ? ST_TOO_SMALL : ST_OK);
         rsp_key_ff    <= pop_empty ? 32'd0 : key_rd;
         rsp_size_ff   <= pop_empty ? 7'd0 : 7'(fill_rd);
         rsp_last_ff   <= 1'b1;
      end else if (cmd.stream) begin
         rsp_status_ff <= ST_OK;
         rsp_key_ff    <= key_rd;
         rsp_size_ff   <= 7'(fill_rd);
         rsp_last_ff   <= stream_last;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         msg_open_ff  <= 1'b0;
         accepting_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= cmd.result || (cmd.pop && !pop_stream) || cmd.stream;
         if (cmd.capture) begin
            if (req_op == OP_POP) begin
               msg_open_ff  <= 1'b0;
               accepting_ff <= 1'b0;
            end else if (req_first_byte) begin
               msg_open_ff  <= 1'b1;
               accepting_ff <= 1'b0;
            end
         end
         if (cmd.search && srch_done) begin
            accepting_ff <= srch_ok;
         end
         if (cmd.result) begin
            msg_open_ff  <= 1'b0;
            accepting_ff <= 1'b0;
         end
         // Commit once the padding is written.
         if (cmd.pad && pad_done) begin
            fill_ff[active_ff] <= start_off_ff + FILL_W'(2) + held_len_ff;
            if (opens_new_ff) begin
               tail_ff  <= ring_next(tail_ff);
               count_ff <= count_ff + 1'b1;
            end
         end
         // Release the head entry after its last byte is read, or at once
         // when it is queued but holds nothing.
         if ((cmd.stream && stream_last)
             || (cmd.pop && !pop_empty && !pop_small && fill_rd == '0)) begin
            fill_ff[head_ff] <= '0;
            head_ff          <= ring_next(head_ff);
            count_ff         <= count_ff - 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rdata_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_entry_size = rsp_size_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule
`default_nettype wire

// ===== sv/keyed_coalescing_ring_queue.sv =====
`default_nettype none
// Keyed coalescing ring queue. Items enter on the req_ ports: pulse start
// while busy is low. An add item carries one message byte; a pop item asks
// for the head entry. Results appear on the rsp_ ports for one cycle each,
// marked by rsp_valid; the receiver cannot stall them.
// A message's first byte searches the queued entries from head toward tail
// for its key, one entry per cycle; if the message is taken, it then writes
// the two length bytes and the data byte into the byte store, one store
// write per cycle. On the last byte of a taken message, data bytes still
// missing are written as zero, one per cycle, and the status result follows.
// A pop that streams an entry of N bytes gives one result per cycle after
// the pop state; a refused or empty pop gives one result.
// The store's single write port and registered read port set these rates.
// Reset empties the ring and closes any open message; no clearing pass is run.
module keyed_coalescing_ring_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [31:0] req_dest_key,
   input  wire logic [15:0] req_msg_length,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic [15:0] req_read_limit,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_out_byte,
   output logic [31:0]      rsp_out_key,
   output logic [6:0]       rsp_entry_size,
   output logic             rsp_out_last
);
   import kcrq_pkg::*;

   kcrq_cmd_type cmd;
   kcrq_sts_type sts;

   kcrq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_op         (req_op),
      .req_first_byte (req_first_byte),
      .sts            (sts),
      .cmd            (cmd),
      .busy           (busy)
   );

   kcrq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_dest_key   (req_dest_key),
      .req_msg_length (req_msg_length),
      .req_msg_byte   (req_msg_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_read_limit (req_read_limit),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_key    (rsp_out_key),
      .rsp_entry_size (rsp_entry_size),
      .rsp_out_last   (rsp_out_last)
   );

endmodule
`default_nettype wire
